// ----- design/ovl_pkg.sv -----
// types and constants shared by the ordered value list engine
// no dependencies; every design file but ovl_ram refers to this package by scoped names
`default_nettype none

package ovl_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  // command codes
  localparam logic [2:0] CMD_FRONT  = 3'd0;
  localparam logic [2:0] CMD_ORDER  = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_DUMP   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [2:0]                cmd;
    logic signed [VALUE_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      entry_valid;
    logic [COUNT_W-1:0]        count;
    logic                      last;
  } out_req_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- design/ordered_value_list_engine.sv -----
// ordered value list engine top level: command sequencer, list store and output register
// depends on ovl_pkg, ovl_ram and ovl_cmp
//
//   channel | direction | payload          | handshake
//   in_     | input     | ovl_pkg::in_req_t  | in_valid / in_stall
//   out_    | output    | ovl_pkg::out_req_t | out_valid / out_stall
//
// every store access is a ram read whose registered data is then compared,
// written back one place up or down, or emitted as a dump result
// rst_n is synchronous; it empties the list and drops out_valid, ram contents stay
// in_stall is high from acceptance until the command's last result is registered
// out_stall holds the output register; the sequencer waits to emit a result while it is stalled
`default_nettype none

module ordered_value_list_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ovl_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ovl_pkg::out_req_t      out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SRCH_RD = 4'd1;
  localparam logic [3:0] S_SRCH_EV = 4'd2;
  localparam logic [3:0] S_SHUP_RD = 4'd3;
  localparam logic [3:0] S_SHUP_WR = 4'd4;
  localparam logic [3:0] S_PUT     = 4'd5;
  localparam logic [3:0] S_SHDN_RD = 4'd6;
  localparam logic [3:0] S_SHDN_WR = 4'd7;
  localparam logic [3:0] S_DUMP_RD = 4'd8;
  localparam logic [3:0] S_DUMP_EV = 4'd9;
  localparam logic [3:0] S_RESP    = 4'd10;

  logic [3:0]                         state_r, state_nxt;
  logic [CW-1:0]                      cnt_r, cnt_nxt;
  logic [CW-1:0]                      idx_r, idx_nxt;
  logic [CW-1:0]                      pos_r, pos_nxt;
  logic [2:0]                         cmd_r, cmd_nxt;
  logic signed [ovl_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [1:0]                         status_r, status_nxt;
  logic                               out_valid_r, out_valid_nxt;
  ovl_pkg::out_req_t                  out_data_r, out_data_nxt;

  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  logic [ovl_pkg::VALUE_W-1:0]        ram_wdata;
  logic                               ram_re;
  logic [AW-1:0]                      ram_raddr;
  logic [ovl_pkg::VALUE_W-1:0]        ram_rdata;
  ovl_pkg::cmp_res_t                  cmp_res;

  logic [CW-1:0]                      idx_inc;
  logic [CW-1:0]                      idx_dec;
  logic [CW:0]                        idx_inc2;
  logic                               out_free;
  logic                               emit;
  ovl_pkg::out_req_t                  emit_data;

  ovl_ram #(
    .WIDTH (ovl_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ovl_cmp u_cmp (
    .stored (ram_rdata),
    .key    (val_r),
    .res    (cmp_res)
  );

  assign idx_inc  = idx_r + CW'(1);
  assign idx_dec  = idx_r - CW'(1);
  assign idx_inc2 = {1'b0, idx_r} + (CW + 1)'(2);
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r[AW-1:0];
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = idx_r[AW-1:0];
    emit       = 1'b0;
    emit_data  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data.cmd;
          val_nxt    = in_data.value;
          status_nxt = ovl_pkg::ST_OK;
          idx_nxt    = '0;
          pos_nxt    = '0;
          state_nxt  = S_RESP;
          case (in_data.cmd)
            ovl_pkg::CMD_FRONT, ovl_pkg::CMD_ORDER: begin
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = ovl_pkg::ST_FULL;
              end else if (in_data.cmd == ovl_pkg::CMD_ORDER && cnt_r != '0) begin
                state_nxt = S_SRCH_RD;
              end else begin
                // insert at the front: move everything up one place
                idx_nxt   = cnt_r;
                state_nxt = (cnt_r != '0) ? S_SHUP_RD : S_PUT;
              end
            end
            ovl_pkg::CMD_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = ovl_pkg::ST_MISSING;
              end else begin
                state_nxt = S_SRCH_RD;
              end
            end
            ovl_pkg::CMD_DUMP: begin
              if (cnt_r != '0) begin
                state_nxt = S_DUMP_RD;
              end
            end
            ovl_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SRCH_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SRCH_EV;
      end

      S_SRCH_EV: begin
        if (cmd_r == ovl_pkg::CMD_ORDER) begin
          if (!cmp_res.lt || idx_inc == cnt_r) begin
            // gap goes before the first entry not less than the value, or at the end
            pos_nxt   = cmp_res.lt ? idx_inc : idx_r;
            idx_nxt   = cnt_r;
            state_nxt = (cnt_r != (cmp_res.lt ? idx_inc : idx_r)) ? S_SHUP_RD : S_PUT;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_SRCH_RD;
          end
        end else begin
          if (cmp_res.eq) begin
            if (idx_inc < cnt_r) begin
              state_nxt = S_SHDN_RD;
            end else begin
              cnt_nxt   = cnt_r - CW'(1);
              state_nxt = S_RESP;
            end
          end else if (idx_inc == cnt_r) begin
            status_nxt = ovl_pkg::ST_MISSING;
            state_nxt  = S_RESP;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_SRCH_RD;
          end
        end
      end

      S_SHUP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_dec[AW-1:0];
        state_nxt = S_SHUP_WR;
      end

      S_SHUP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_dec;
        state_nxt = (idx_dec > pos_r) ? S_SHUP_RD : S_PUT;
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_RESP;
      end

      S_SHDN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_inc[AW-1:0];
        state_nxt = S_SHDN_WR;
      end

      S_SHDN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        if (idx_inc2 < {1'b0, cnt_r}) begin
          state_nxt = S_SHDN_RD;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_DUMP_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_DUMP_EV;
      end

      S_DUMP_EV: begin
        // read data holds while a stalled result occupies the output register
        if (out_free) begin
          emit                  = 1'b1;
          emit_data.status      = ovl_pkg::ST_OK;
          emit_data.entry_value = ram_rdata;
          emit_data.entry_valid = 1'b1;
          emit_data.count       = ovl_pkg::COUNT_W'(cnt_r);
          emit_data.last        = (idx_inc == cnt_r);
          idx_nxt               = idx_inc;
          state_nxt             = (idx_inc == cnt_r) ? S_IDLE : S_DUMP_RD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_data.status      = status_r;
          emit_data.entry_value = '0;
          emit_data.entry_valid = 1'b0;
          emit_data.count       = ovl_pkg::COUNT_W'(cnt_r);
          emit_data.last        = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- design/ovl_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module ovl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/ovl_cmp.sv -----
// shared compare unit: signed less-than and equality of a stored value
// against the request value; depends on ovl_pkg
`default_nettype none

module ovl_cmp (
  input  wire logic signed [ovl_pkg::VALUE_W-1:0] stored,
  input  wire logic signed [ovl_pkg::VALUE_W-1:0] key,
  output ovl_pkg::cmp_res_t                       res
);

  always_comb begin
    res.lt = stored < key;
    res.eq = stored == key;
  end

endmodule

`default_nettype wire

// ----- design/ovl_chk.sv -----
// port-level checker for the ordered value list engine, bound to the top level
// depends on ovl_pkg and ordered_value_list_engine
`default_nettype none

module ovl_chk #(
  parameter int unsigned DEPTH = 16
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire ovl_pkg::out_req_t out_data
);

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result request changed");

  // an accepted command makes the input side busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a command");

  // a result without a dumped entry is the only one of its command and carries zero
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.entry_valid |-> out_data.last && out_data.entry_value == '0)
    else $error("non-dump result not last or not zero");

  // count never exceeds the store depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.count <= ovl_pkg::COUNT_W'(DEPTH))
    else $error("reported count exceeds depth");

endmodule

bind ordered_value_list_engine ovl_chk #(
  .DEPTH (DEPTH)
) u_ovl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
